>>> src/mapped_region_table_assert.svh
// assertion macros for the mapped region table
`ifndef MAPPED_REGION_TABLE_ASSERT_SVH
`define MAPPED_REGION_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MRT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mapped region table check failed");

// next-cycle implication, checked out of reset
`define MRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mapped region table check failed");

`endif

>>> src/mrt_pkg.sv
// shared types, constants and helpers of the mapped region table
`default_nettype none
package mrt_pkg;

  localparam int MAX_REGIONS_DEF = 16;
  localparam int PAGE_BITS_DEF   = 12;

  localparam logic [31:0] AREA_START_RESET = 32'h4000_0000;
  localparam logic [31:0] AREA_END_RESET   = 32'hBFFF_F000;
  localparam logic [31:0] NO_HANDLE        = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_MAP   = 2'd0;
  localparam logic [1:0] OP_UNMAP = 2'd1;
  localparam logic [1:0] OP_PROT  = 2'd2;
  localparam logic [1:0] OP_FAULT = 2'd3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_END   = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic [2:0]  prot;
    logic        anon;
    logic [31:0] handle;
    logic [31:0] offset;
  } entry_t;

  typedef struct packed {
    logic push;
    logic drop;
  } ord_cmd_t;

  function automatic logic [3:0] flags_of(input logic [2:0] p);
    logic [3:0] f;
    f = 4'b0011;
    f[2] = p[1];
    f[3] = ~p[2];
    return f;
  endfunction

endpackage
`default_nettype wire

>>> src/mrt_in_if.sv
// request channel of the mapped region table
`default_nettype none
interface mrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] address;
  logic [31:0] length;
  logic [2:0]  prot;
  logic [1:0]  map_options;
  logic [31:0] file_handle;
  logic [31:0] file_pos;

  modport source (output valid, opcode, address, length, prot, map_options, file_handle,
                  file_pos, input ready);
  modport sink (input valid, opcode, address, length, prot, map_options, file_handle,
                file_pos, output ready);
endinterface
`default_nettype wire

>>> src/mrt_out_if.sv
// result channel of the mapped region table
`default_nettype none
interface mrt_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] result_address;
  logic [3:0]  page_flags;
  logic        file_backed;
  logic [31:0] backing_handle;
  logic [32:0] backing_offset;
  logic [31:0] release_start;
  logic [31:0] release_length;

  modport source (output valid, status, result_address, page_flags, file_backed,
                  backing_handle, backing_offset, release_start, release_length,
                  input ready);
  modport sink (input valid, status, result_address, page_flags, file_backed,
                backing_handle, backing_offset, release_start, release_length,
                output ready);
endinterface
`default_nettype wire

>>> src/mrt_store.sv
// region record memory, one write port and one registered read port
`default_nettype none
module mrt_store #(
  parameter int MAX_REGIONS = mrt_pkg::MAX_REGIONS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [$clog2(MAX_REGIONS)-1:0] waddr,
  input  wire mrt_pkg::entry_t                wdata,
  input  wire logic [$clog2(MAX_REGIONS)-1:0] raddr,
  output mrt_pkg::entry_t                     rdata
);

  mrt_pkg::entry_t mem [MAX_REGIONS];
  mrt_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> src/mrt_order.sv
// age order list: slot of each live region, newest first, plus slot valid bits
`default_nettype none
module mrt_order #(
  parameter int MAX_REGIONS = mrt_pkg::MAX_REGIONS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire mrt_pkg::ord_cmd_t                cmd,
  input  wire logic [$clog2(MAX_REGIONS)-1:0]   age,
  output logic [$clog2(MAX_REGIONS)-1:0]        slot,
  output logic [$clog2(MAX_REGIONS)-1:0]        free_slot,
  output logic [$clog2(MAX_REGIONS+1)-1:0]      count
);

  localparam int SLOT_W = $clog2(MAX_REGIONS);
  localparam int CNT_W  = $clog2(MAX_REGIONS + 1);

  logic [SLOT_W-1:0]      order_r   [MAX_REGIONS];
  logic [SLOT_W-1:0]      order_nxt [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SLOT_W-1:0]      free_w;

  // lowest free slot
  always_comb begin
    free_w = '0;
    for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_w = SLOT_W'(i);
    end
  end

  always_comb begin
    order_nxt = order_r;
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (cmd.push) begin
      for (int k = MAX_REGIONS - 1; k >= 1; k--) begin
        order_nxt[k] = order_r[k-1];
      end
      order_nxt[0]      = free_w;
      valid_nxt[free_w] = 1'b1;
      count_nxt         = count_r + CNT_W'(1);
    end else if (cmd.drop) begin
      for (int k = 0; k < MAX_REGIONS - 1; k++) begin
        if (k >= int'(age)) order_nxt[k] = order_r[k+1];
      end
      valid_nxt[order_r[age]] = 1'b0;
      count_nxt               = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    order_r <= order_nxt;
  end

  assign slot      = order_r[age];
  assign free_slot = free_w;
  assign count     = count_r;

endmodule
`default_nettype wire

>>> src/mapped_region_table.sv
// mapped region table top level: sequencer around the record memory
//
// channel  dir  handshake       word
// in_ch    in   valid / ready   opcode, address, length, prot, map_options, file_*
// out_ch   out  valid / ready   status, result_address, page_flags, backing_*, release_*
// cfg      in   cfg_we only     cfg_index, cfg_wdata (area_start, area_end)
//
// one request at a time; each live region looked at takes a memory read (S_RD) and a check (S_EV)
// unmap, protect, fault: scan the live regions newest first until a hit or the end of the list
// map with search: each candidate is checked against the live regions until an overlap, candidates up to live + 2
// reset is synchronous and clears the valid bits at once, no clearing pass is needed
// a finished result waits in the output register while the next request is taken
`default_nettype none
module mapped_region_table #(
  parameter int MAX_REGIONS = mrt_pkg::MAX_REGIONS_DEF,
  parameter int PAGE_BITS   = mrt_pkg::PAGE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mrt_in_if.sink                             in_ch,
  mrt_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [mrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_wdata
);

  localparam int SLOT_W = $clog2(MAX_REGIONS);
  localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
  localparam logic [32:0]      PAGE_MASK = (33'd1 << PAGE_BITS) - 33'd1;
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_REGIONS);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FCHK = 3'd1;  // first-fit bound check of a candidate
  localparam logic [2:0] S_RD   = 3'd2;  // read the region at the current age
  localparam logic [2:0] S_EV   = 3'd3;  // check the region just read
  localparam logic [2:0] S_POST = 3'd4;  // fixed map after its inner unmap
  localparam logic [2:0] S_INS  = 3'd5;  // write the new region
  localparam logic [2:0] S_DONE = 3'd6;  // hand the word to the output register

  // scan kinds
  localparam logic [1:0] M_UNMAP = 2'd0;
  localparam logic [1:0] M_PROT  = 2'd1;
  localparam logic [1:0] M_FAULT = 2'd2;
  localparam logic [1:0] M_FIT   = 2'd3;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic        fixed_r, fixed_nxt;
  logic        hphase_r, hphase_nxt;       // still trying the hint
  logic [CNT_W-1:0] idx_r, idx_nxt;        // age being scanned
  logic [32:0] cand_r, cand_nxt;           // first-fit candidate, 33 bits
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] len_r, len_nxt;
  logic [32:0] size_r, size_nxt;           // page-rounded length
  logic [2:0]  prot_r, prot_nxt;
  logic        anon_r, anon_nxt;
  logic [31:0] hdl_r, hdl_nxt;
  logic [31:0] foff_r, foff_nxt;
  logic [31:0] where_r, where_nxt;

  // result being built
  logic        st_r, st_nxt;
  logic [31:0] ra_r, ra_nxt;
  logic [3:0]  pf_r, pf_nxt;
  logic        fb_r, fb_nxt;
  logic [31:0] bh_r, bh_nxt;
  logic [32:0] bo_r, bo_nxt;
  logic [31:0] rs_r, rs_nxt;
  logic [31:0] rl_r, rl_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic        ost_r;
  logic [31:0] ora_r;
  logic [3:0]  opf_r;
  logic        ofb_r;
  logic [31:0] obh_r;
  logic [32:0] obo_r;
  logic [31:0] ors_r;
  logic [31:0] orl_r;
  logic        out_load;

  // configuration and hint
  logic [31:0] area_start_r, area_end_r;
  logic [31:0] hint_r, hint_nxt;

  // order list and memory
  mrt_pkg::ord_cmd_t ord_cmd;
  logic [SLOT_W-1:0] ord_slot, free_slot;
  logic [CNT_W-1:0]  count;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  mrt_pkg::entry_t   mem_wdata, ent;

  mrt_order #(.MAX_REGIONS(MAX_REGIONS)) u_order (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ord_cmd),
    .age       (idx_r[SLOT_W-1:0]),
    .slot      (ord_slot),
    .free_slot (free_slot),
    .count     (count)
  );

  mrt_store #(.MAX_REGIONS(MAX_REGIONS)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (ord_slot),
    .rdata (ent)
  );

  // request side arithmetic
  logic        in_acc;
  logic [32:0] in_size;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_size     = ({1'b0, in_ch.length} + PAGE_MASK) & ~PAGE_MASK;

  // region checks against the word just read
  logic [32:0] ent_end, addr_sz, addr_len;
  logic [33:0] cand_sz;
  logic        hit_exact, hit_contain_sz, hit_contain_len, hit_fault, hit_overlap;

  assign ent_end  = {1'b0, ent.start} + {1'b0, ent.size};
  assign addr_sz  = {1'b0, addr_r} + size_r;
  assign addr_len = {1'b0, addr_r} + {1'b0, len_r};
  assign cand_sz  = {1'b0, cand_r} + {1'b0, size_r};

  assign hit_exact       = (ent.start == addr_r) && ({1'b0, ent.size} == size_r);
  assign hit_contain_sz  = (ent.start <= addr_r) && (addr_sz <= ent_end);
  assign hit_contain_len = (ent.start <= addr_r) && (addr_len <= ent_end);
  assign hit_fault       = (addr_r >= ent.start) && ({1'b0, addr_r} < ent_end);
  assign hit_overlap     = !((cand_sz <= {2'b0, ent.start}) || (cand_r >= ent_end));

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    fixed_nxt  = fixed_r;
    hphase_nxt = hphase_r;
    idx_nxt    = idx_r;
    cand_nxt   = cand_r;
    addr_nxt   = addr_r;
    len_nxt    = len_r;
    size_nxt   = size_r;
    prot_nxt   = prot_r;
    anon_nxt   = anon_r;
    hdl_nxt    = hdl_r;
    foff_nxt   = foff_r;
    where_nxt  = where_r;
    st_nxt     = st_r;
    ra_nxt     = ra_r;
    pf_nxt     = pf_r;
    fb_nxt     = fb_r;
    bh_nxt     = bh_r;
    bo_nxt     = bo_r;
    rs_nxt     = rs_r;
    rl_nxt     = rl_r;
    hint_nxt   = hint_r;
    ord_cmd    = '0;
    mem_we     = 1'b0;
    mem_waddr  = ord_slot;
    mem_wdata  = ent;
    out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          addr_nxt  = in_ch.address;
          len_nxt   = in_ch.length;
          size_nxt  = in_size;
          prot_nxt  = in_ch.prot;
          anon_nxt  = in_ch.map_options[1];
          // anonymous regions and the none handle store handle zero
          hdl_nxt   = (!in_ch.map_options[1] && (in_ch.file_handle != mrt_pkg::NO_HANDLE))
                      ? in_ch.file_handle : 32'd0;
          foff_nxt  = in_ch.file_pos;
          where_nxt = in_ch.address;
          idx_nxt   = '0;
          fixed_nxt = 1'b0;
          st_nxt    = 1'b1;
          ra_nxt    = '0;
          pf_nxt    = '0;
          fb_nxt    = 1'b0;
          bh_nxt    = '0;
          bo_nxt    = '0;
          rs_nxt    = '0;
          rl_nxt    = '0;
          state_nxt = S_DONE;
          case (in_ch.opcode)
            mrt_pkg::OP_MAP: begin
              if ((in_ch.length != 32'd0) && !in_size[32]) begin
                if (in_ch.map_options[0]) begin
                  // fixed map: unmap the target range first
                  if (in_ch.address != 32'd0) begin
                    mode_nxt  = M_UNMAP;
                    fixed_nxt = 1'b1;
                    state_nxt = S_RD;
                  end
                end else if (count < CNT_MAX) begin
                  if (in_ch.address != 32'd0) begin
                    state_nxt = S_INS;
                  end else begin
                    mode_nxt   = M_FIT;
                    cand_nxt   = {1'b0, hint_r};
                    hphase_nxt = 1'b1;
                    state_nxt  = S_FCHK;
                  end
                end
              end
            end
            mrt_pkg::OP_UNMAP: begin
              if ((in_ch.address != 32'd0) && !in_size[32]) begin
                mode_nxt  = M_UNMAP;
                state_nxt = S_RD;
              end
            end
            mrt_pkg::OP_PROT: begin
              if (in_ch.address != 32'd0) begin
                mode_nxt  = M_PROT;
                state_nxt = S_RD;
              end
            end
            default: begin
              mode_nxt  = M_FAULT;
              state_nxt = S_RD;
            end
          endcase
        end
      end

      S_FCHK: begin
        idx_nxt = '0;
        if (cand_sz <= {2'b0, area_end_r}) begin
          state_nxt = S_RD;
        end else if (hphase_r) begin
          // hint did not fit, restart from the bottom of the area
          cand_nxt   = {1'b0, area_start_r};
          hphase_nxt = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RD: begin
        if (idx_r >= count) begin
          // scanned every live region without a hit
          case (mode_r)
            M_UNMAP: state_nxt = fixed_r ? S_POST : S_DONE;
            M_FIT: begin
              where_nxt = cand_r[31:0];
              hint_nxt  = cand_sz[31:0];
              state_nxt = S_INS;
            end
            default: state_nxt = S_DONE;
          endcase
        end else begin
          state_nxt = S_EV;
        end
      end

      S_EV: begin
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = S_RD;
        case (mode_r)
          M_UNMAP: begin
            if (hit_exact) begin
              rs_nxt       = ent.start;
              rl_nxt       = ent.size;
              ord_cmd.drop = 1'b1;
            end else if (hit_contain_sz) begin
              // region only contains the range: keep it, release the pages
              rs_nxt = addr_r;
              rl_nxt = size_r[31:0];
            end
            if (hit_exact || hit_contain_sz) begin
              if (fixed_r) begin
                state_nxt = S_POST;
              end else begin
                st_nxt    = 1'b0;
                state_nxt = S_DONE;
              end
            end
          end
          M_PROT: begin
            if (hit_contain_len) begin
              mem_we         = 1'b1;
              mem_waddr      = ord_slot;
              mem_wdata      = ent;
              mem_wdata.prot = prot_r;
              pf_nxt         = mrt_pkg::flags_of(prot_r);
              st_nxt         = 1'b0;
              state_nxt      = S_DONE;
            end
          end
          M_FAULT: begin
            if (hit_fault) begin
              pf_nxt    = mrt_pkg::flags_of(ent.prot);
              fb_nxt    = !ent.anon && (ent.handle != 32'd0);
              bh_nxt    = ent.handle;
              bo_nxt    = {1'b0, ent.offset} + {1'b0, addr_r - ent.start};
              st_nxt    = 1'b0;
              state_nxt = S_DONE;
            end
          end
          default: begin
            if (hit_overlap) begin
              // newest overlapping region: jump past it, or leave the hint
              cand_nxt   = hphase_r ? {1'b0, area_start_r} : ent_end;
              hphase_nxt = 1'b0;
              state_nxt  = S_FCHK;
            end
          end
        endcase
      end

      S_POST: begin
        state_nxt = (count < CNT_MAX) ? S_INS : S_DONE;
      end

      S_INS: begin
        ord_cmd.push     = 1'b1;
        mem_we           = 1'b1;
        mem_waddr        = free_slot;
        mem_wdata.start  = where_r;
        mem_wdata.size   = size_r[31:0];
        mem_wdata.prot   = prot_r;
        mem_wdata.anon   = anon_r;
        mem_wdata.handle = hdl_r;
        mem_wdata.offset = foff_r;
        st_nxt           = 1'b0;
        ra_nxt           = where_r;
        state_nxt        = S_DONE;
      end

      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_load) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ov_r         <= 1'b0;
      hint_r       <= mrt_pkg::AREA_START_RESET;
      area_start_r <= mrt_pkg::AREA_START_RESET;
      area_end_r   <= mrt_pkg::AREA_END_RESET;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      hint_r  <= hint_nxt;
      if (cfg_we && (cfg_index == mrt_pkg::CFG_AREA_START)) area_start_r <= cfg_wdata;
      if (cfg_we && (cfg_index == mrt_pkg::CFG_AREA_END))   area_end_r   <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    fixed_r  <= fixed_nxt;
    hphase_r <= hphase_nxt;
    idx_r    <= idx_nxt;
    cand_r   <= cand_nxt;
    addr_r   <= addr_nxt;
    len_r    <= len_nxt;
    size_r   <= size_nxt;
    prot_r   <= prot_nxt;
    anon_r   <= anon_nxt;
    hdl_r    <= hdl_nxt;
    foff_r   <= foff_nxt;
    where_r  <= where_nxt;
    st_r     <= st_nxt;
    ra_r     <= ra_nxt;
    pf_r     <= pf_nxt;
    fb_r     <= fb_nxt;
    bh_r     <= bh_nxt;
    bo_r     <= bo_nxt;
    rs_r     <= rs_nxt;
    rl_r     <= rl_nxt;
    if (out_load) begin
      ost_r <= st_r;
      ora_r <= ra_r;
      opf_r <= pf_r;
      ofb_r <= fb_r;
      obh_r <= bh_r;
      obo_r <= bo_r;
      ors_r <= rs_r;
      orl_r <= rl_r;
    end
  end

  assign out_ch.valid          = ov_r;
  assign out_ch.status         = ost_r;
  assign out_ch.result_address = ora_r;
  assign out_ch.page_flags     = opf_r;
  assign out_ch.file_backed    = ofb_r;
  assign out_ch.backing_handle = obh_r;
  assign out_ch.backing_offset = obo_r;
  assign out_ch.release_start  = ors_r;
  assign out_ch.release_length = orl_r;

  `include "mapped_region_table_assert.svh"

  // live region count never passes the table size
  `MRT_ASSERT_IMPL(a_count_max, 1'b1, count <= CNT_MAX)
  // a new region is written only while a slot is free
  `MRT_ASSERT_IMPL(a_push_room, ord_cmd.push, count < CNT_MAX)
  // a taken word leaves the output unless the next one is loaded
  `MRT_ASSERT_NEXT(a_out_drain, out_ch.valid && out_ch.ready && !out_load, !out_ch.valid)
  // a region is dropped only while one is live
  `MRT_ASSERT_IMPL(a_drop_live, ord_cmd.drop, count != '0)

endmodule
`default_nettype wire
